/* rtl/core/quaternion_vector_rotation_macros.svh */
// Assertion macros shared by the quaternion rotation RTL.
`ifndef QUATERNION_VECTOR_ROTATION_MACROS_SVH
`define QUATERNION_VECTOR_ROTATION_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define QVR_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("quaternion rotation check failed");

// Next-cycle implication.
`define QVR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("quaternion rotation check failed");

`endif

/* rtl/core/qvr_pkg.sv */
// Shared constants and types of the quaternion vector rotation block.
package qvr_pkg;

   localparam int VEC_WIDTH_DEF   = 32;
   localparam int ROTOR_WIDTH_DEF = 32;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ROTOR_W = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ROTOR_X = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ROTOR_Y = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ROTOR_Z = 2'd3;

   typedef struct packed {
      logic busy;
      logic degenerate;
   } norm_status_type;

endpackage

/* rtl/core/qvr_product.sv */
// Four-stage pipeline forming t = q*(0,v) and the vector part of t*conj(q).
module qvr_product #(
   parameter int VEC_WIDTH   = qvr_pkg::VEC_WIDTH_DEF,
   parameter int ROTOR_WIDTH = qvr_pkg::ROTOR_WIDTH_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       in_valid,
   input  logic signed [VEC_WIDTH-1:0]                vx,
   input  logic signed [VEC_WIDTH-1:0]                vy,
   input  logic signed [VEC_WIDTH-1:0]                vz,
   input  logic signed [ROTOR_WIDTH-1:0]              qw,
   input  logic signed [ROTOR_WIDTH-1:0]              qx,
   input  logic signed [ROTOR_WIDTH-1:0]              qy,
   input  logic signed [ROTOR_WIDTH-1:0]              qz,
   output logic                                       out_valid,
   output logic signed [VEC_WIDTH+ROTOR_WIDTH+5:0]    n1,
   output logic signed [VEC_WIDTH+ROTOR_WIDTH+5:0]    n2,
   output logic signed [VEC_WIDTH+ROTOR_WIDTH+5:0]    n3
);
   localparam int PW   = VEC_WIDTH + ROTOR_WIDTH;
   localparam int SUMW = PW + 2;
   localparam int FRAC = ROTOR_WIDTH - 2;
   localparam int TW   = VEC_WIDTH + 4;
   localparam int MW   = TW + ROTOR_WIDTH;
   localparam int NW   = MW + 2;
   localparam logic signed [SUMW-1:0] HALF = SUMW'(1) <<< (FRAC - 1);

   function automatic logic signed [TW-1:0] round_shift(input logic signed [SUMW-1:0] s);
      logic signed [SUMW-1:0] r;
      r = (s + HALF) >>> FRAC;
      return r[TW-1:0];
   endfunction

   logic [3:0] valid_ff;

   // Stage 1: products of the rotor with the vector.
   logic signed [PW-1:0] a_xvx_ff, a_yvy_ff, a_zvz_ff;
   logic signed [PW-1:0] a_wvx_ff, a_yvz_ff, a_zvy_ff;
   logic signed [PW-1:0] a_wvy_ff, a_zvx_ff, a_xvz_ff;
   logic signed [PW-1:0] a_wvz_ff, a_xvy_ff, a_yvx_ff;
   // Stage 2: t, rounded back to vector scale.
   logic signed [TW-1:0] t0_ff, t1_ff, t2_ff, t3_ff;
   logic signed [TW-1:0] t0_in, t1_in, t2_in, t3_in;
   // Stage 3: products of t with the rotor.
   logic signed [MW-1:0] b_t0x_ff, b_t0y_ff, b_t0z_ff;
   logic signed [MW-1:0] b_t1w_ff, b_t2w_ff, b_t3w_ff;
   logic signed [MW-1:0] b_t1z_ff, b_t1y_ff, b_t2z_ff;
   logic signed [MW-1:0] b_t2x_ff, b_t3y_ff, b_t3x_ff;
   // Stage 4: numerators.
   logic signed [NW-1:0] n1_ff, n2_ff, n3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      a_xvx_ff <= qx * vx;
      a_yvy_ff <= qy * vy;
      a_zvz_ff <= qz * vz;
      a_wvx_ff <= qw * vx;
      a_yvz_ff <= qy * vz;
      a_zvy_ff <= qz * vy;
      a_wvy_ff <= qw * vy;
      a_zvx_ff <= qz * vx;
      a_xvz_ff <= qx * vz;
      a_wvz_ff <= qw * vz;
      a_xvy_ff <= qx * vy;
      a_yvx_ff <= qy * vx;
   end

   always_comb begin
      t0_in = round_shift(-(SUMW'(a_xvx_ff) + SUMW'(a_yvy_ff) + SUMW'(a_zvz_ff)));
      t1_in = round_shift(SUMW'(a_wvx_ff) + SUMW'(a_yvz_ff) - SUMW'(a_zvy_ff));
      t2_in = round_shift(SUMW'(a_wvy_ff) + SUMW'(a_zvx_ff) - SUMW'(a_xvz_ff));
      t3_in = round_shift(SUMW'(a_wvz_ff) + SUMW'(a_xvy_ff) - SUMW'(a_yvx_ff));
   end

   always_ff @(posedge clock) begin
      t0_ff <= t0_in;
      t1_ff <= t1_in;
      t2_ff <= t2_in;
      t3_ff <= t3_in;
   end

   always_ff @(posedge clock) begin
      b_t0x_ff <= t0_ff * qx;
      b_t0y_ff <= t0_ff * qy;
      b_t0z_ff <= t0_ff * qz;
      b_t1w_ff <= t1_ff * qw;
      b_t2w_ff <= t2_ff * qw;
      b_t3w_ff <= t3_ff * qw;
      b_t1z_ff <= t1_ff * qz;
      b_t1y_ff <= t1_ff * qy;
      b_t2z_ff <= t2_ff * qz;
      b_t2x_ff <= t2_ff * qx;
      b_t3y_ff <= t3_ff * qy;
      b_t3x_ff <= t3_ff * qx;
   end

   // The conjugate's negated vector part is folded into the signs here.
   always_ff @(posedge clock) begin
      n1_ff <= -NW'(b_t0x_ff) + NW'(b_t1w_ff) - NW'(b_t2z_ff) + NW'(b_t3y_ff);
      n2_ff <= -NW'(b_t0y_ff) + NW'(b_t2w_ff) - NW'(b_t3x_ff) + NW'(b_t1z_ff);
      n3_ff <= -NW'(b_t0z_ff) + NW'(b_t3w_ff) - NW'(b_t1y_ff) + NW'(b_t2x_ff);
   end

   assign out_valid = valid_ff[3];
   assign n1 = n1_ff;
   assign n2 = n2_ff;
   assign n3 = n3_ff;

endmodule

/* rtl/core/qvr_div_lane.sv */
// Pipelined restoring divider, one quotient bit per stage, with rounding and saturation.
module qvr_div_lane #(
   parameter int VEC_WIDTH   = qvr_pkg::VEC_WIDTH_DEF,
   parameter int ROTOR_WIDTH = qvr_pkg::ROTOR_WIDTH_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   input  logic signed [VEC_WIDTH+ROTOR_WIDTH+5:0] num,
   input  logic        [ROTOR_WIDTH:0]             den,
   output logic                                    out_valid,
   output logic signed [VEC_WIDTH-1:0]             quo
);
   localparam int NW = VEC_WIDTH + ROTOR_WIDTH + 6;
   localparam int LW = ROTOR_WIDTH + 1;
   localparam int QW = VEC_WIDTH + 1;
   localparam int HW = NW - QW;
   localparam int RW2 = QW + 1;
   localparam logic [RW2-1:0] LIM = RW2'(1) << (VEC_WIDTH - 1);

   logic [NW-1:0] mag;
   logic [HW-1:0] hi;
   logic          sat_in;

   logic          valid_ff [0:QW];
   logic [LW-1:0] rem_ff   [0:QW];
   logic [QW-1:0] low_ff   [0:QW];
   logic [QW-1:0] q_ff     [0:QW];
   logic          neg_ff   [0:QW];
   logic          sat_ff   [0:QW];

   logic [RW2-1:0]       rq;
   logic [RW2-1:0]       mag_res;
   logic signed [VEC_WIDTH-1:0] quo_in;
   logic signed [VEC_WIDTH-1:0] quo_ff;
   logic                 out_valid_ff;

   // Front stage: magnitude, and an early overflow check on the high part.
   always_comb begin
      mag    = num[NW-1] ? NW'(-num) : NW'(num);
      hi     = mag[NW-1:QW];
      sat_in = hi >= HW'(den);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= sat_in ? '0 : hi[LW-1:0];
      low_ff[0] <= mag[QW-1:0];
      q_ff[0]   <= '0;
      neg_ff[0] <= num[NW-1];
      sat_ff[0] <= sat_in;
   end

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic [LW:0]   r2;
      logic          ge;
      logic [LW:0]   diff;

      always_comb begin
         r2   = {rem_ff[k], low_ff[k][QW-1]};
         ge   = r2 >= {1'b0, den};
         diff = r2 - {1'b0, den};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k+1] <= ge ? diff[LW-1:0] : r2[LW-1:0];
         low_ff[k+1] <= {low_ff[k][QW-2:0], 1'b0};
         q_ff[k+1]   <= {q_ff[k][QW-2:0], ge};
         neg_ff[k+1] <= neg_ff[k];
         sat_ff[k+1] <= sat_ff[k];
      end
   end

   // Round half away from zero on the magnitude, then clamp to the signed range.
   always_comb begin
      rq = RW2'(q_ff[QW]) + RW2'({rem_ff[QW], 1'b0} >= {1'b0, den});
      if (neg_ff[QW]) begin
         mag_res = (sat_ff[QW] || rq > LIM) ? LIM : rq;
         quo_in  = VEC_WIDTH'(-mag_res);
      end else begin
         mag_res = (sat_ff[QW] || rq > LIM - 1'b1) ? LIM - 1'b1 : rq;
         quo_in  = VEC_WIDTH'(mag_res);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= valid_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
   end

   assign out_valid = out_valid_ff;
   assign quo       = quo_ff;

endmodule

/* rtl/core/qvr_norm.sv */
// Sequencer that sums the rotor's squares and takes the integer square root.
module qvr_norm #(
   parameter int ROTOR_WIDTH = qvr_pkg::ROTOR_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          restart,
   input  logic signed [ROTOR_WIDTH-1:0] qw,
   input  logic signed [ROTOR_WIDTH-1:0] qx,
   input  logic signed [ROTOR_WIDTH-1:0] qy,
   input  logic signed [ROTOR_WIDTH-1:0] qz,
   output logic        [ROTOR_WIDTH:0]   length,
   output qvr_pkg::norm_status_type      status
);
   localparam int SW = 2 * ROTOR_WIDTH + 2;
   localparam int LW = ROTOR_WIDTH + 1;
   localparam int MW = ROTOR_WIDTH + 2;
   localparam int CW = $clog2(ROTOR_WIDTH + 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SQUARE = 2'd1;
   localparam logic [1:0] ST_ROOT   = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic [LW-1:0] root_ff, root_in;
   logic [MW-1:0] rem_ff, rem_in;
   logic [LW-1:0] len_ff, len_in;
   logic          degen_ff, degen_in;

   logic signed [ROTOR_WIDTH-1:0]   comp;
   logic signed [2*ROTOR_WIDTH-1:0] sq;
   logic [MW+1:0] r2;
   logic [MW+1:0] trial;
   logic          ge;

   always_comb begin
      unique case (cnt_ff[1:0])
         2'd0:    comp = qw;
         2'd1:    comp = qx;
         2'd2:    comp = qy;
         default: comp = qz;
      endcase
      sq    = comp * comp;
      r2    = {rem_ff, sum_ff[SW-1:SW-2]};
      trial = (MW+2)'({root_ff, 2'b01});
      ge    = r2 >= trial;

      state_in = state_ff;
      cnt_in   = cnt_ff;
      sum_in   = sum_ff;
      root_in  = root_ff;
      rem_in   = rem_ff;
      len_in   = len_ff;
      degen_in = degen_ff;

      if (restart) begin
         state_in = ST_SQUARE;
         cnt_in   = '0;
         sum_in   = '0;
      end else begin
         unique case (state_ff)
            ST_SQUARE: begin
               sum_in = sum_ff + SW'($unsigned(sq));
               if (cnt_ff == CW'(3)) begin
                  state_in = ST_ROOT;
                  cnt_in   = '0;
                  root_in  = '0;
                  rem_in   = '0;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
            ST_ROOT: begin
               // One result bit per cycle, two radicand bits shifted in.
               sum_in  = {sum_ff[SW-3:0], 2'b00};
               rem_in  = ge ? MW'(r2 - trial) : MW'(r2);
               root_in = {root_ff[LW-2:0], ge};
               if (cnt_ff == CW'(ROTOR_WIDTH)) begin
                  state_in = ST_IDLE;
                  len_in   = root_in;
                  degen_in = (root_in == '0);
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
            ST_IDLE: begin
               state_in = ST_IDLE;
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         len_ff   <= LW'(1) << (ROTOR_WIDTH - 2);
         degen_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         len_ff   <= len_in;
         degen_ff <= degen_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff  <= sum_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
   end

   assign length            = len_ff;
   assign status.busy       = (state_ff != ST_IDLE);
   assign status.degenerate = degen_ff;

endmodule

/* rtl/core/quaternion_vector_rotation.sv */
// Top level of the quaternion vector rotation block.
//
//   Channel   Ports                              Transfer
//   request   start, busy, req_in_x/y/z          start high while busy low
//   response  rsp_valid, rsp_out_x/y/z, rsp_deg. every cycle rsp_valid is high
//   config    csr_we, csr_index, csr_wdata       every cycle csr_we is high
//
// One vector enters per cycle while busy is low; its result passes through four
// product stages, then one divider stage per quotient bit plus two.
// A register write starts the rotor length unit: first the sum of the squares,
// then the square root, with busy high throughout both.
// Reset loads the unit rotor with length one, so busy is low right after reset.
// The response side has no back-pressure; the pipeline never stalls.
`include "quaternion_vector_rotation_macros.svh"

module quaternion_vector_rotation #(
   parameter int VEC_WIDTH   = qvr_pkg::VEC_WIDTH_DEF,
   parameter int ROTOR_WIDTH = qvr_pkg::ROTOR_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [VEC_WIDTH-1:0]           req_in_x,
   input  logic signed [VEC_WIDTH-1:0]           req_in_y,
   input  logic signed [VEC_WIDTH-1:0]           req_in_z,
   output logic                                  rsp_valid,
   output logic signed [VEC_WIDTH-1:0]           rsp_out_x,
   output logic signed [VEC_WIDTH-1:0]           rsp_out_y,
   output logic signed [VEC_WIDTH-1:0]           rsp_out_z,
   output logic                                  rsp_degenerate,
   input  logic                                  csr_we,
   input  logic [qvr_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [ROTOR_WIDTH-1:0]                csr_wdata
);
   localparam int NW = VEC_WIDTH + ROTOR_WIDTH + 6;

   logic signed [ROTOR_WIDTH-1:0] rotor_w_ff, rotor_x_ff, rotor_y_ff, rotor_z_ff;

   qvr_pkg::norm_status_type norm_status;
   logic [ROTOR_WIDTH:0]     length;

   logic                 prod_valid;
   logic signed [NW-1:0] n1, n2, n3;

   logic                        vld_x, vld_y, vld_z;
   logic signed [VEC_WIDTH-1:0] quo_x, quo_y, quo_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         rotor_w_ff <= ROTOR_WIDTH'(1) << (ROTOR_WIDTH - 2);
         rotor_x_ff <= '0;
         rotor_y_ff <= '0;
         rotor_z_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            qvr_pkg::REG_ROTOR_W: rotor_w_ff <= csr_wdata;
            qvr_pkg::REG_ROTOR_X: rotor_x_ff <= csr_wdata;
            qvr_pkg::REG_ROTOR_Y: rotor_y_ff <= csr_wdata;
            qvr_pkg::REG_ROTOR_Z: rotor_z_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   qvr_norm #(.ROTOR_WIDTH(ROTOR_WIDTH)) u_norm (
      .clock   (clock),
      .reset   (reset),
      .restart (csr_we),
      .qw      (rotor_w_ff),
      .qx      (rotor_x_ff),
      .qy      (rotor_y_ff),
      .qz      (rotor_z_ff),
      .length  (length),
      .status  (norm_status)
   );

   assign busy = norm_status.busy;

   qvr_product #(.VEC_WIDTH(VEC_WIDTH), .ROTOR_WIDTH(ROTOR_WIDTH)) u_product (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .vx        (req_in_x),
      .vy        (req_in_y),
      .vz        (req_in_z),
      .qw        (rotor_w_ff),
      .qx        (rotor_x_ff),
      .qy        (rotor_y_ff),
      .qz        (rotor_z_ff),
      .out_valid (prod_valid),
      .n1        (n1),
      .n2        (n2),
      .n3        (n3)
   );

   qvr_div_lane #(.VEC_WIDTH(VEC_WIDTH), .ROTOR_WIDTH(ROTOR_WIDTH)) u_div_x (
      .clock (clock), .reset (reset), .in_valid (prod_valid),
      .num (n1), .den (length), .out_valid (vld_x), .quo (quo_x)
   );

   qvr_div_lane #(.VEC_WIDTH(VEC_WIDTH), .ROTOR_WIDTH(ROTOR_WIDTH)) u_div_y (
      .clock (clock), .reset (reset), .in_valid (prod_valid),
      .num (n2), .den (length), .out_valid (vld_y), .quo (quo_y)
   );

   qvr_div_lane #(.VEC_WIDTH(VEC_WIDTH), .ROTOR_WIDTH(ROTOR_WIDTH)) u_div_z (
      .clock (clock), .reset (reset), .in_valid (prod_valid),
      .num (n3), .den (length), .out_valid (vld_z), .quo (quo_z)
   );

   // A zero rotor has length zero; the divider output is then meaningless.
   assign rsp_valid      = vld_x;
   assign rsp_degenerate = norm_status.degenerate;
   assign rsp_out_x      = norm_status.degenerate ? '0 : quo_x;
   assign rsp_out_y      = norm_status.degenerate ? '0 : quo_y;
   assign rsp_out_z      = norm_status.degenerate ? '0 : quo_z;

   `QVR_ASSERT_IMPLY(a_lanes_aligned, 1'b1, (vld_y == vld_x) && (vld_z == vld_x))
   `QVR_ASSERT_NEXT(a_write_sets_busy, csr_we, busy)
   `QVR_ASSERT_IMPLY(a_length_on_done, $fell(busy), (length != '0) || norm_status.degenerate)

endmodule

/* dv/tb_quaternion_vector_rotation.sv */
// Self-checking testbench for the quaternion vector rotation block.
`timescale 1ns / 1ps

module tb_quaternion_vector_rotation;

   localparam int VW = 32;
   localparam int RW = 32;
   localparam int LATENCY = VW + 8;
   localparam int IDLE_LIMIT = 5000;
   localparam logic signed [VW-1:0] VMAX = 32'sh7fff_ffff;
   localparam logic signed [VW-1:0] VMIN = 32'sh8000_0000;
   localparam logic signed [RW-1:0] ONE_Q30 = 32'sh4000_0000;
   localparam logic signed [RW-1:0] COS45 = 32'sd759250125;

   typedef struct {
      logic signed [VW-1:0] x;
      logic signed [VW-1:0] y;
      logic signed [VW-1:0] z;
      logic                 degenerate;
   } rotated_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [VW-1:0] req_in_x = '0, req_in_y = '0, req_in_z = '0;
   logic rsp_valid;
   logic signed [VW-1:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic rsp_degenerate;
   logic csr_we = 1'b0;
   logic [qvr_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [RW-1:0] csr_wdata = '0;

   // Testbench copy of the rotor registers.
   logic signed [RW-1:0] rotor_w, rotor_x, rotor_y, rotor_z;

   rotated_type expected_q[$];
   int errors = 0;
   int vectors_sent = 0;
   int results_seen = 0;
   int degenerate_seen = 0;
   int rotors_loaded = 0;
   int idle_cycles = 0;
   int burst_left = 1;

   quaternion_vector_rotation uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_in_x(req_in_x), .req_in_y(req_in_y), .req_in_z(req_in_z),
      .rsp_valid(rsp_valid), .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y),
      .rsp_out_z(rsp_out_z), .rsp_degenerate(rsp_degenerate),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [127:0] rotor_length(logic [127:0] sum_sq);
      logic [127:0] root;
      logic [127:0] trial;
      root = '0;
      for (int i = 62; i >= 0; i--) begin
         trial = root | (128'd1 << i);
         if (trial * trial <= sum_sq) root = trial;
      end
      return root;
   endfunction

   // Divide with rounding half away from zero, then clamp to the vector range.
   function automatic logic signed [VW-1:0] scale_and_clamp(logic signed [127:0] num,
                                                            logic [127:0] len);
      logic [127:0] mag, quo, rem;
      logic neg;
      neg = num < 0;
      mag = neg ? -num : num;
      quo = mag / len;
      rem = mag % len;
      if (rem >= len - rem) quo = quo + 1;
      if (!neg) return (quo > 128'h7fff_ffff) ? VMAX : quo[VW-1:0];
      if (quo >= 128'h8000_0000) return VMIN;
      return -quo[VW-1:0];
   endfunction

   function automatic rotated_type rotate_vector(logic signed [VW-1:0] vx,
                                                 logic signed [VW-1:0] vy,
                                                 logic signed [VW-1:0] vz);
      logic signed [127:0] w, x, y, z, ax, ay, az, s, t0, t1, t2, t3, n1, n2, n3;
      logic signed [127:0] half;
      logic [127:0] len;
      rotated_type r;
      w = rotor_w; x = rotor_x; y = rotor_y; z = rotor_z;
      ax = vx; ay = vy; az = vz;
      half = 128'sh2000_0000;
      s = w * w + x * x + y * y + z * z;
      r.x = '0; r.y = '0; r.z = '0; r.degenerate = 1'b1;
      if (s == 0) return r;
      len = rotor_length(s);
      t0 = (-(x * ax + y * ay + z * az) + half) >>> (RW - 2);
      t1 = (w * ax + y * az - z * ay + half) >>> (RW - 2);
      t2 = (w * ay + z * ax - x * az + half) >>> (RW - 2);
      t3 = (w * az + x * ay - y * ax + half) >>> (RW - 2);
      n1 = t0 * (-x) + w * t1 + t2 * (-z) - (-y) * t3;
      n2 = t0 * (-y) + w * t2 + t3 * (-x) - (-z) * t1;
      n3 = t0 * (-z) + w * t3 + t1 * (-y) - (-x) * t2;
      r.x = scale_and_clamp(n1, len);
      r.y = scale_and_clamp(n2, len);
      r.z = scale_and_clamp(n3, len);
      r.degenerate = 1'b0;
      return r;
   endfunction

   // Result checker and watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_valid || csr_we) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog expired with %0d results pending", $time,
                     expected_q.size());
            $display("Simulation FAILED");
            $finish;
         end
         if (rsp_valid) begin
            results_seen++;
            if (expected_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result expected none actual %h %h %h deg %b",
                        $time, rsp_out_x, rsp_out_y, rsp_out_z, rsp_degenerate);
            end else begin
               rotated_type e;
               e = expected_q.pop_front();
               if (e.degenerate) degenerate_seen++;
               if (rsp_out_x !== e.x || rsp_out_y !== e.y || rsp_out_z !== e.z ||
                   rsp_degenerate !== e.degenerate) begin
                  errors++;
                  $display("%0t: mismatch expected %h %h %h deg %b actual %h %h %h deg %b",
                           $time, e.x, e.y, e.z, e.degenerate,
                           rsp_out_x, rsp_out_y, rsp_out_z, rsp_degenerate);
               end
            end
         end
      end
   end

   // Sends one vector; the sender runs in bursts separated by random gaps.
   task automatic send_vector(logic signed [VW-1:0] vx, logic signed [VW-1:0] vy,
                              logic signed [VW-1:0] vz);
      start <= 1'b1;
      req_in_x <= vx;
      req_in_y <= vy;
      req_in_z <= vz;
      do @(posedge clock); while (busy);
      expected_q.push_back(rotate_vector(vx, vy, vz));
      vectors_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                 : $urandom_range(1, 12);
      end
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [qvr_pkg::CSR_INDEX_WIDTH-1:0] idx, logic [RW-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         qvr_pkg::REG_ROTOR_W: rotor_w = value;
         qvr_pkg::REG_ROTOR_X: rotor_x = value;
         qvr_pkg::REG_ROTOR_Y: rotor_y = value;
         qvr_pkg::REG_ROTOR_Z: rotor_z = value;
      endcase
   endtask

   // Loads a new rotor once the pipeline is empty, then waits for the length unit.
   task automatic load_rotor(logic [RW-1:0] w, logic [RW-1:0] x, logic [RW-1:0] y,
                             logic [RW-1:0] z);
      drain_results();
      write_reg(qvr_pkg::REG_ROTOR_W, w);
      write_reg(qvr_pkg::REG_ROTOR_X, x);
      write_reg(qvr_pkg::REG_ROTOR_Y, y);
      write_reg(qvr_pkg::REG_ROTOR_Z, z);
      csr_we <= 1'b0;
      do @(posedge clock); while (!busy);
      do @(posedge clock); while (busy);
      rotors_loaded++;
   endtask

   function automatic logic signed [VW-1:0] pick_component();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? VMAX : VMIN;
         2: return $signed($urandom_range(0, 200)) - 100;
         3: return ($signed($urandom_range(0, 2000)) - 1000) <<< 16;
         default: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
      endcase
   endfunction

   function automatic logic [RW-1:0] pick_rotor_part(int kind);
      case (kind)
         0: return $urandom;
         1: return $signed($urandom_range(0, 32'h8000_0000)) - ONE_Q30;
         default: return $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
      endcase
   endfunction

   task automatic test_identity_extremes();
      send_vector(VMAX, VMIN, 0);
      send_vector(VMIN, VMAX, -1);
      send_vector(0, 0, 0);
      send_vector(1, -1, 32'sh0001_0000);
      send_vector(VMAX, VMAX, VMAX);
      send_vector(VMIN, VMIN, VMIN);
   endtask

   task automatic test_quarter_turn();
      load_rotor(COS45, 0, 0, COS45);
      send_vector(32'sh0001_0000, 0, 0);
      send_vector(0, 32'sh0001_0000, 32'sh0002_0000);
      send_vector(VMAX, VMIN, VMAX);
      load_rotor(0, ONE_Q30, 0, 0);
      send_vector(32'sh0003_0000, -32'sh0001_8000, 7);
      send_vector(VMIN, VMAX, VMIN);
   endtask

   task automatic test_rotor_extremes();
      // A rotor far from unit length scales the vector and drives saturation.
      load_rotor(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      send_vector(VMAX, VMIN, VMAX);
      send_vector(32'sh0001_0000, 1, -1);
      load_rotor(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      send_vector(VMIN, VMIN, VMAX);
      send_vector(-5, 3, 32'sh0000_8000);
      load_rotor(0, 0, 0, 1);
      send_vector(VMAX, VMAX, VMIN);
   endtask

   task automatic test_zero_rotor();
      load_rotor(0, 0, 0, 0);
      send_vector(VMAX, VMIN, 32'sh0001_0000);
      send_vector(0, 0, 0);
   endtask

   task automatic test_random_rotations();
      int kind;
      for (int phase = 0; phase < 10; phase++) begin
         kind = phase % 3;
         if (phase == 7) load_rotor(0, 0, 0, 0);
         else load_rotor(pick_rotor_part(kind), pick_rotor_part(kind),
                         pick_rotor_part(kind), pick_rotor_part(kind));
         repeat (80) send_vector(pick_component(), pick_component(), pick_component());
      end
   endtask

   initial begin
      rotor_w = ONE_Q30; rotor_x = '0; rotor_y = '0; rotor_z = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_identity_extremes();
      test_quarter_turn();
      test_rotor_extremes();
      test_zero_rotor();
      test_random_rotations();
      drain_results();
      repeat (LATENCY) @(posedge clock);
      $display("Rotated %0d vectors under %0d rotor settings; %0d results checked,",
               vectors_sent, rotors_loaded, results_seen);
      $display("%0d of them with a zero-length rotor.", degenerate_seen);
      if (errors == 0 && expected_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/qvr_pkg.sv
rtl/core/qvr_product.sv
rtl/core/qvr_div_lane.sv
rtl/core/qvr_norm.sv
rtl/core/quaternion_vector_rotation.sv
dv/tb_quaternion_vector_rotation.sv
